// ----- rtl/agcm_pkg.sv -----
`timescale 1ns / 1ps
package agcm_pkg;

  localparam int unsigned NumRounds  = 14;
  localparam int unsigned NumRkWords = 30;
  localparam logic [7:0]  GhashPoly  = 8'he1;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_AAD    = 2'd1,
    CMD_DATA   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TAG   = 2'd1,
    ST_ORDER = 2'd2,
    ST_OVF   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_AAD  = 2'd1,
    PH_DATA = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    CFG_KEY0   = 3'd0,
    CFG_KEY1   = 3'd1,
    CFG_KEY2   = 3'd2,
    CFG_KEY3   = 3'd3,
    CFG_NONCEH = 3'd4,
    CFG_NONCEL = 3'd5,
    CFG_DECRYPT = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_KEXP,
    S_AES_H,
    S_AES_J0,
    S_AES_CTR,
    S_GHASH,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  valid_bytes;
  } in_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic [1:0]  status;
  } out_t;

  // control from the sequencer to the aes round unit
  typedef struct packed {
    logic start;
    logic [127:0] block;
  } aes_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return b[7] ? ({b[6:0], 1'b0} ^ 8'h1b) : {b[6:0], 1'b0};
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // leading-bytes mask over 128 bits, byte 0 at the top
  function automatic logic [127:0] byte_mask(input logic [4:0] v);
    logic [127:0] m;
    for (int i = 0; i < 16; i++) begin
      m[127 - 8*i -: 8] = (5'(i) < v) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

// ----- rtl/aes256_gcm_engine.sv -----
`timescale 1ns / 1ps
// start runs the key schedule, then two aes blocks (hash key, then encrypted j0);
// a data block runs an aes block, then a ghash multiply, aad and finish a multiply, rejects neither
// one transaction at a time: the shared round unit and ghash multiplier set the rate
// the result sits in an output register until taken; next input is taken after that
// reset clears phase, counts, accumulator and handshake state; round keys undefined until start
module aes256_gcm_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  agcm_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output agcm_pkg::out_t     out_data_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);
  import agcm_pkg::*;

  // configuration registers
  logic [255:0] key_q;
  logic [63:0]  nonce_h_q;
  logic [31:0]  nonce_l_q;
  logic         decrypt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      nonce_h_q <= '0;
      nonce_l_q <= '0;
      decrypt_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_KEY0:    key_q[255:192] <= cfg_data_i;
        CFG_KEY1:    key_q[191:128] <= cfg_data_i;
        CFG_KEY2:    key_q[127:64]  <= cfg_data_i;
        CFG_KEY3:    key_q[63:0]    <= cfg_data_i;
        CFG_NONCEH:  nonce_h_q      <= cfg_data_i;
        CFG_NONCEL:  nonce_l_q      <= cfg_data_i[31:0];
        CFG_DECRYPT: decrypt_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e       state_q, state_d;
  phase_e       phase_q, phase_d;
  in_t          item_q, item_d;
  logic [127:0] h_q, h_d, ej0_q, ej0_d, acc_q, acc_d;
  logic [31:0]  ctr_q, ctr_d, aad_q, aad_d, dat_q, dat_d;
  out_t         res_q, res_d;
  logic         ov_q, ov_d;
  // key schedule: two 128-bit halves, sliding window
  logic [255:0] kw_q, kw_d;
  logic [0:0]   kstep_q, kstep_d;
  logic [7:0]   rcon_q, rcon_d;
  logic [3:0]   kaddr_q, kaddr_d;

  aes_ctl_t     aes_ctl;
  logic         aes_done;
  logic [127:0] aes_res;
  logic         rk_we;
  logic [3:0]   rk_waddr;
  logic [127:0] rk_wdata;
  logic         gh_start, gh_done;
  logic [127:0] gh_x, gh_z;

  agcm_aes_round u_aes (
    .clk_i, .rst_ni,
    .ctl_i      (aes_ctl),
    .rk_we_i    (rk_we),
    .rk_waddr_i (rk_waddr),
    .rk_wdata_i (rk_wdata),
    .done_o     (aes_done),
    .result_o   (aes_res)
  );

  agcm_ghash u_gh (
    .clk_i, .rst_ni,
    .start_i (gh_start),
    .x_i     (gh_x),
    .h_i     (h_q),
    .done_o  (gh_done),
    .z_o     (gh_z)
  );

  logic         acc_item;
  logic [4:0]   vb;
  logic [127:0] mask, blk, ks_out;
  logic [32:0]  aad_sum, dat_sum;
  logic         in_order;

  assign acc_item = in_valid_i && !in_stall_o;
  assign vb       = (item_q.valid_bytes > 5'd16) ? 5'd16 : item_q.valid_bytes;
  assign mask     = byte_mask(vb);
  assign blk      = {item_q.block_high, item_q.block_low};
  assign ks_out   = (blk ^ aes_res) & mask;
  assign aad_sum  = {1'b0, aad_q} + 33'(vb);
  assign dat_sum  = {1'b0, dat_q} + 33'(vb);

  // next-word function of the key schedule, 256-bit window, one 128-bit half a step
  function automatic logic [127:0] kexp_half(input logic [255:0] w, input logic odd,
                                             input logic [7:0] rc);
    logic [31:0] t, a, b, c, d;
    t = w[31:0];
    if (!odd) t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'd0};
    else      t = sub_word(t);
    a = w[255:224] ^ t;
    b = w[223:192] ^ a;
    c = w[191:160] ^ b;
    d = w[159:128] ^ c;
    return {a, b, c, d};
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc_item) begin
          priority if (in_data_i.cmd == CMD_START) state_d = S_KEXP;
          else state_d = S_GHASH;
        end
      end
      S_KEXP:    if (kaddr_q == 4'(NumRounds)) state_d = S_AES_H;
      S_AES_H:   if (aes_done) state_d = S_AES_J0;
      S_AES_J0:  if (aes_done) state_d = S_DONE;
      S_AES_CTR: if (aes_done) state_d = S_GHASH;
      S_GHASH: begin
        // first cycle here decides; later waits on multiplier
        if (ov_q) begin
          if (gh_done) state_d = S_DONE;
        end else if (item_q.cmd == CMD_DATA && in_order && !dat_sum[32]
                     && vb != 5'd0 && !kstep_q[0]) begin
          state_d = S_AES_CTR;
        end else if (!gh_start) begin
          state_d = S_DONE;
        end
      end
      S_DONE:    if (!out_stall_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (item_q.cmd)
      CMD_AAD:    in_order = (phase_q == PH_AAD) && (aad_q[3:0] == 4'd0);
      CMD_DATA:   in_order = (phase_q == PH_AAD || phase_q == PH_DATA) && (dat_q[3:0] == 4'd0);
      CMD_FINISH: in_order = (phase_q == PH_AAD || phase_q == PH_DATA);
      default:    in_order = 1'b1;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    logic [127:0] tag;
    item_d   = item_q;
    phase_d  = phase_q;
    h_d      = h_q;
    ej0_d    = ej0_q;
    acc_d    = acc_q;
    ctr_d    = ctr_q;
    aad_d    = aad_q;
    dat_d    = dat_q;
    res_d    = res_q;
    ov_d     = ov_q;
    kw_d     = kw_q;
    kstep_d  = kstep_q;
    rcon_d   = rcon_q;
    kaddr_d  = kaddr_q;
    aes_ctl  = '0;
    rk_we    = 1'b0;
    rk_waddr = kaddr_q;
    rk_wdata = kw_q[255:128];
    gh_start = 1'b0;
    gh_x     = acc_q;
    tag      = gh_z ^ ej0_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc_item) begin
          item_d  = in_data_i;
          ov_d    = 1'b0;
          kstep_d = '0;
          kw_d    = key_q;
          rcon_d  = 8'h01;
          kaddr_d = '0;
        end
      end
      S_KEXP: begin
        // store current upper half, then slide window
        rk_we   = 1'b1;
        kaddr_d = kaddr_q + 4'd1;
        kw_d    = {kw_q[127:0], kexp_half(kw_q, kaddr_q[0], rcon_q)};
        if (kaddr_q[0]) rcon_d = xtime(rcon_q);
        if (kaddr_q == 4'(NumRounds)) begin
          aes_ctl.start = 1'b1;
          aes_ctl.block = '0;
        end
      end
      S_AES_H: begin
        if (aes_done) begin
          h_d           = aes_res;
          aes_ctl.start = 1'b1;
          aes_ctl.block = {nonce_h_q, nonce_l_q, 32'd1};
        end
      end
      S_AES_J0: begin
        if (aes_done) begin
          ej0_d   = aes_res;
          acc_d   = '0;
          ctr_d   = '0;
          aad_d   = '0;
          dat_d   = '0;
          phase_d = PH_AAD;
          res_d   = '{out_high: '0, out_low: '0, status: ST_OK};
        end
      end
      S_AES_CTR: begin
        if (aes_done) begin
          res_d.out_high = ks_out[127:64];
          res_d.out_low  = ks_out[63:0];
          kstep_d[0]     = 1'b1;
        end
      end
      S_GHASH: begin
        if (ov_q) begin
          // multiplier running; collect result
          if (gh_done) begin
            acc_d = gh_z;
            if (item_q.cmd == CMD_FINISH) begin
              res_d.out_high = tag[127:64];
              res_d.out_low  = tag[63:0];
              res_d.status   = (decrypt_q && (tag != blk)) ? ST_TAG : ST_OK;
              phase_d        = PH_DONE;
            end
          end
        end else begin
          res_d = '{out_high: res_q.out_high & {64{kstep_q[0]}},
                    out_low: res_q.out_low & {64{kstep_q[0]}}, status: ST_OK};
          if (!in_order) begin
            res_d.status = ST_ORDER;
          end else if (item_q.cmd == CMD_AAD && aad_sum[32]) begin
            res_d.status = ST_OVF;
          end else if (item_q.cmd == CMD_DATA && dat_sum[32]) begin
            res_d.status = ST_OVF;
          end else if (item_q.cmd == CMD_AAD) begin
            if (vb != 5'd0) begin
              gh_start = 1'b1;
              gh_x     = acc_q ^ (blk & mask);
              aad_d    = aad_sum[31:0];
              ov_d     = 1'b1;
            end
          end else if (item_q.cmd == CMD_DATA) begin
            phase_d = PH_DATA;
            if (vb != 5'd0 && !kstep_q[0]) begin
              aes_ctl.start = 1'b1;
              aes_ctl.block = {nonce_h_q, nonce_l_q, ctr_q + 32'd2};
            end else if (vb != 5'd0) begin
              gh_start = 1'b1;
              gh_x     = acc_q ^ (decrypt_q ? (blk & mask)
                                            : {res_q.out_high, res_q.out_low});
              ctr_d    = ctr_q + 32'd1;
              dat_d    = dat_sum[31:0];
              ov_d     = 1'b1;
            end
          end else if (item_q.cmd == CMD_FINISH) begin
            gh_start = 1'b1;
            gh_x     = acc_q ^ {29'd0, aad_q, 3'd0, 29'd0, dat_q, 3'd0};
            ov_d     = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      ctr_q   <= '0;
      aad_q   <= '0;
      dat_q   <= '0;
      ov_q    <= 1'b0;
      kstep_q <= '0;
      kaddr_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      acc_q   <= acc_d;
      ctr_q   <= ctr_d;
      aad_q   <= aad_d;
      dat_q   <= dat_d;
      ov_q    <= ov_d;
      kstep_q <= kstep_d;
      kaddr_q <= kaddr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    h_q    <= h_d;
    ej0_q  <= ej0_d;
    res_q  <= res_d;
    kw_q   <= kw_d;
    rcon_q <= rcon_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_DONE);
  assign out_data_o  = res_q;

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open while result pending");
  a_phase_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AES_J0 && aes_done) |=> phase_q == PH_AAD)
    else $error("start did not open aad phase");
  a_reject_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_q.status == ST_ORDER) |-> $stable(acc_q))
    else $error("rejected item changed hash state");

endmodule

// ----- rtl/agcm_aes_round.sv -----
`timescale 1ns / 1ps
// one aes-256 round per cycle, round keys from a 15 x 128 store
module agcm_aes_round (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  agcm_pkg::aes_ctl_t      ctl_i,
  input  logic                    rk_we_i,
  input  logic [3:0]              rk_waddr_i,
  input  logic [127:0]            rk_wdata_i,
  output logic                    done_o,
  output logic [127:0]            result_o
);
  import agcm_pkg::*;

  logic [127:0] rk_mem [NumRounds + 1];
  logic [127:0] rk_rd_q;
  logic [3:0]   rnd_q, rnd_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [127:0] st_q, st_d;
  logic [127:0] sb, sr, mc, rnd_out;

  // round key memory, registered read of the next round key
  always_ff @(posedge clk_i) begin
    if (rk_we_i) begin
      rk_mem[rk_waddr_i] <= rk_wdata_i;
    end
    rk_rd_q <= rk_mem[rnd_d];
  end

  // subbytes, shiftrows, mixcolumns on the state
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[127 - 8*i -: 8] = sbox(st_q[127 - 8*i -: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sr[127 - 8*(i + 4*c) -: 8] = sb[127 - 8*(i + 4*((c + i) % 4)) -: 8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3;
      a0 = sr[127 - 32*c -: 8];
      a1 = sr[119 - 32*c -: 8];
      a2 = sr[111 - 32*c -: 8];
      a3 = sr[103 - 32*c -: 8];
      mc[127 - 32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      mc[119 - 32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      mc[111 - 32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      mc[103 - 32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    rnd_out = ((rnd_q == 4'(NumRounds)) ? sr : mc) ^ rk_rd_q;
  end

  // round sequencing: first cycle fetches key 0, then one round each cycle
  always_comb begin
    rnd_d  = rnd_q;
    busy_d = busy_q;
    done_d = 1'b0;
    st_d   = st_q;
    if (ctl_i.start) begin
      rnd_d  = 4'd0;
      busy_d = 1'b1;
      st_d   = ctl_i.block;
    end else if (busy_q) begin
      rnd_d = rnd_q + 4'd1;
      if (rnd_q == 4'd0) begin
        st_d = st_q ^ rk_rd_q;
      end else begin
        st_d = rnd_out;
      end
      if (rnd_q == 4'(NumRounds)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        rnd_d  = 4'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rnd_q  <= rnd_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign done_o   = done_q;
  assign result_o = st_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done with unit still busy");
  a_rnd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> rnd_q == 4'd0) else $error("round count nonzero while idle");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_q) else $error("aes start while busy");

endmodule

// ----- rtl/agcm_ghash.sv -----
`timescale 1ns / 1ps
// gf(2^128) multiply, eight bits of x per cycle
module agcm_ghash (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [127:0]  x_i,
  input  logic [127:0]  h_i,
  output logic          done_o,
  output logic [127:0]  z_o
);
  import agcm_pkg::*;

  logic [127:0] x_q, x_d, z_q, z_d, v_q, v_d;
  logic [3:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d, done_q, done_d;

  always_comb begin
    logic [127:0] z, v;
    x_d    = x_q;
    z_d    = z_q;
    v_d    = v_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    z      = z_q;
    v      = v_q;
    if (start_i) begin
      x_d    = x_i;
      z_d    = '0;
      v_d    = h_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int i = 0; i < 8; i++) begin
        if (x_q[127 - i]) begin
          z = z ^ v;
        end
        v = v[0] ? ({1'b0, v[127:1]} ^ {GhashPoly, 120'd0}) : {1'b0, v[127:1]};
      end
      z_d   = z;
      v_d   = v;
      x_d   = {x_q[119:0], 8'd0};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    z_q <= z_d;
    v_q <= v_d;
  end

  assign done_o = done_q;
  assign z_o    = z_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("ghash done while busy");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("ghash start while busy");
  a_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> cnt_q == 4'd0) else $error("ghash count out of step");

endmodule

// ----- tb/tb_aes256_gcm_engine.sv -----
`timescale 1ns / 1ps
module tb_aes256_gcm_engine;
  import agcm_pkg::*;

  localparam int unsigned CycleLimit = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aes256_gcm_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  // mirror of the configuration registers
  logic [63:0]  key_w [4];
  logic [63:0]  nonce_hi;
  logic [31:0]  nonce_lo;
  logic         dec_mode;

  // mirror of the engine state
  logic [127:0] rkey_sched [15];
  logic [127:0] h_key;
  logic [127:0] ej0;
  logic [127:0] ghash_acc;
  logic [31:0]  ctr_count;
  logic [31:0]  aad_bytes;
  logic [31:0]  data_bytes;
  phase_e       msg_phase;

  logic [7:0]   sb [256];
  out_t         pending_results [$];
  int unsigned  errors = 0;
  int unsigned  results_seen = 0;
  int unsigned  cycles = 0;
  bit           calm = 1'b0;

  // gf(2^8) arithmetic for building the s-box
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
    end
    return p;
  endfunction

  function automatic logic [7:0] mul2(input logic [7:0] a);
    return gf_mul(a, 8'h02);
  endfunction

  function automatic logic [7:0] byte_at(input logic [127:0] w, input int i);
    return w[127 - 8*i -: 8];
  endfunction

  // aes-256 encryption of one block with the mirrored round keys
  function automatic logic [127:0] aes_encrypt(input logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [127:0] w;
    w = blk ^ rkey_sched[0];
    for (int r = 1; r <= 14; r++) begin
      for (int i = 0; i < 16; i++) s[i] = sb[byte_at(w, i)];
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i + 4*c] = s[i + 4*((c + i) & 3)];
      if (r < 14) begin
        for (int c = 0; c < 4; c++) begin
          s[4*c]   = mul2(t[4*c]) ^ mul2(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
          s[4*c+1] = t[4*c] ^ mul2(t[4*c+1]) ^ mul2(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
          s[4*c+2] = t[4*c] ^ t[4*c+1] ^ mul2(t[4*c+2]) ^ mul2(t[4*c+3]) ^ t[4*c+3];
          s[4*c+3] = mul2(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ mul2(t[4*c+3]);
        end
      end else begin
        s = t;
      end
      for (int i = 0; i < 16; i++) w[127 - 8*i -: 8] = s[i];
      w ^= rkey_sched[r];
    end
    return w;
  endfunction

  // aes-256 key schedule from the key registers
  function automatic void expand_keys();
    logic [7:0] ks [240];
    logic [7:0] t [4];
    logic [7:0] rcon;
    logic [7:0] tmp;
    logic [255:0] k;
    rcon = 8'h01;
    k = {key_w[0], key_w[1], key_w[2], key_w[3]};
    for (int i = 0; i < 32; i++) ks[i] = k[255 - 8*i -: 8];
    for (int n = 32; n < 240; n += 4) begin
      for (int i = 0; i < 4; i++) t[i] = ks[n - 4 + i];
      if (n % 32 == 0) begin
        tmp = t[0];
        t[0] = sb[t[1]] ^ rcon;
        t[1] = sb[t[2]];
        t[2] = sb[t[3]];
        t[3] = sb[tmp];
        rcon = mul2(rcon);
      end else if (n % 32 == 16) begin
        for (int i = 0; i < 4; i++) t[i] = sb[t[i]];
      end
      for (int i = 0; i < 4; i++) ks[n + i] = ks[n - 32 + i] ^ t[i];
    end
    for (int r = 0; r < 15; r++)
      for (int i = 0; i < 16; i++) rkey_sched[r][127 - 8*i -: 8] = ks[16*r + i];
  endfunction

  // (acc ^ x) * h in gcm bit order
  function automatic logic [127:0] ghash_step(input logic [127:0] acc, input logic [127:0] x);
    logic [127:0] z, v, a;
    logic lsb;
    a = acc ^ x;
    z = '0;
    v = h_key;
    for (int i = 0; i < 128; i++) begin
      if (a[127 - i]) z ^= v;
      lsb = v[0];
      v = v >> 1;
      if (lsb) v[127:120] ^= GhashPoly;
    end
    return z;
  endfunction

  function automatic logic [127:0] lead_mask(input int v);
    logic [127:0] m;
    for (int i = 0; i < 16; i++) m[127 - 8*i -: 8] = (i < v) ? 8'hff : 8'h00;
    return m;
  endfunction

  function automatic logic [127:0] tag_now();
    return ghash_step(ghash_acc, {29'd0, aad_bytes, 3'd0, 29'd0, data_bytes, 3'd0}) ^ ej0;
  endfunction

  // expected result of one transaction; advances the mirrored state
  function automatic out_t gcm_predict(input in_t it);
    out_t o;
    int v;
    logic [127:0] blk, m, ks, res;
    v = (it.valid_bytes > 16) ? 16 : int'(it.valid_bytes);
    blk = {it.block_high, it.block_low};
    o = '0;
    o.status = ST_OK;
    case (cmd_e'(it.cmd))
      CMD_START: begin
        expand_keys();
        h_key = aes_encrypt('0);
        ej0 = aes_encrypt({nonce_hi, nonce_lo, 32'd1});
        ghash_acc = '0;
        ctr_count = '0;
        aad_bytes = '0;
        data_bytes = '0;
        msg_phase = PH_AAD;
      end
      CMD_AAD: begin
        if (msg_phase != PH_AAD || aad_bytes[3:0] != 0) o.status = ST_ORDER;
        else if ({1'b0, aad_bytes} + 33'(v) > 33'hffff_ffff) o.status = ST_OVF;
        else if (v != 0) begin
          ghash_acc = ghash_step(ghash_acc, blk & lead_mask(v));
          aad_bytes += 32'(v);
        end
      end
      CMD_DATA: begin
        if (!(msg_phase inside {PH_AAD, PH_DATA}) || data_bytes[3:0] != 0)
          o.status = ST_ORDER;
        else if ({1'b0, data_bytes} + 33'(v) > 33'hffff_ffff) o.status = ST_OVF;
        else begin
          msg_phase = PH_DATA;
          if (v != 0) begin
            m = lead_mask(v);
            ks = aes_encrypt({nonce_hi, nonce_lo, ctr_count + 32'd2});
            res = (blk ^ ks) & m;
            {o.out_high, o.out_low} = res;
            ghash_acc = ghash_step(ghash_acc, dec_mode ? (blk & m) : res);
            ctr_count += 32'd1;
            data_bytes += 32'(v);
          end
        end
      end
      default: begin
        if (!(msg_phase inside {PH_AAD, PH_DATA})) o.status = ST_ORDER;
        else begin
          res = tag_now();
          ghash_acc = res ^ ej0;
          {o.out_high, o.out_low} = res;
          if (dec_mode && res != blk) o.status = ST_TAG;
          msg_phase = PH_DONE;
        end
      end
    endcase
    return o;
  endfunction

  // offer one transaction; predict it once accepted
  task automatic send_item(input in_t it, input bit fixed, input out_t fixed_res);
    int gap;
    out_t p;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    p = gcm_predict(it);
    pending_results.push_back(fixed ? fixed_res : p);
  endtask

  // write every register while the engine is idle
  task automatic write_config(input logic [255:0] k, input logic [95:0] n, input bit d);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      case (cfg_idx_e'(i))
        CFG_KEY0:   cfg_data <= k[255:192];
        CFG_KEY1:   cfg_data <= k[191:128];
        CFG_KEY2:   cfg_data <= k[127:64];
        CFG_KEY3:   cfg_data <= k[63:0];
        CFG_NONCEH: cfg_data <= n[95:32];
        CFG_NONCEL: cfg_data <= {32'd0, n[31:0]};
        default:    cfg_data <= {63'd0, d};
      endcase
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    {key_w[0], key_w[1], key_w[2], key_w[3]} = k;
    {nonce_hi, nonce_lo} = n;
    dec_mode = d;
  endtask

  function automatic in_t mk(input cmd_e c, input logic [127:0] b, input logic [4:0] v);
    in_t it;
    it.cmd = c;
    {it.block_high, it.block_low} = b;
    it.valid_bytes = v;
    return it;
  endfunction

  function automatic logic [127:0] rnd128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [4:0] rnd_len();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'd16;
  endfunction

  // directed stimulus table
  typedef struct {
    in_t  item;
    bit   fixed;
    out_t res;
  } row_t;

  row_t rows [$];

  function automatic void add_row(input in_t it, input bit fixed, input status_e st);
    row_t r;
    r.item = it;
    r.fixed = fixed;
    r.res = '{out_high: '0, out_low: '0, status: st};
    rows.push_back(r);
  endfunction

  // result side: random stalls, one long hold, field checks
  initial begin
    int n;
    out_t e;
    forever begin
      n = calm ? 0 : $urandom_range(0, 4);
      if (results_seen == 300) n = 400;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_data.out_high != e.out_high) begin
          $display("%0t: out_high expected %h actual %h", $time, e.out_high, out_data.out_high);
          errors++;
        end
        if (out_data.out_low != e.out_low) begin
          $display("%0t: out_low expected %h actual %h", $time, e.out_low, out_data.out_low);
          errors++;
        end
        if (out_data.status != e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_data.status);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // periodic stretches with no idling on either side
  always @(posedge clk_i) begin
    if (cycles % 2000 == 0) calm <= ~calm;
  end

  initial begin
    int items;
    int n_aad, n_data;
    logic [127:0] t;
    logic [127:0] ones;
    ones = '1;
    for (int i = 0; i < 256; i++) begin
      logic [7:0] a, b;
      a = 8'(i);
      b = (i == 0) ? 8'h00 : 8'h01;
      for (int k = 0; k < 254; k++) b = (i == 0) ? 8'h00 : gf_mul(b, a);
      if (i == 1) b = 8'h01;
      sb[i] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
              ^ {b[3:0], b[7:4]} ^ 8'h63;
    end
    for (int i = 0; i < 4; i++) key_w[i] = '0;
    nonce_hi = '0;
    nonce_lo = '0;
    dec_mode = 1'b0;
    ghash_acc = '0;
    ctr_count = '0;
    aad_bytes = '0;
    data_bytes = '0;
    msg_phase = PH_IDLE;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part with the reset configuration
    add_row(mk(CMD_AAD, rnd128(), 5'd16), 1, ST_ORDER);
    add_row(mk(CMD_DATA, rnd128(), 5'd16), 1, ST_ORDER);
    add_row(mk(CMD_FINISH, rnd128(), 5'd0), 1, ST_ORDER);
    add_row(mk(CMD_START, '0, 5'd0), 1, ST_OK);
    add_row(mk(CMD_AAD, ones, 5'd16), 1, ST_OK);
    add_row(mk(CMD_AAD, rnd128(), 5'd5), 1, ST_OK);
    add_row(mk(CMD_AAD, rnd128(), 5'd16), 1, ST_ORDER);
    add_row(mk(CMD_DATA, ones, 5'd0), 1, ST_OK);
    add_row(mk(CMD_DATA, ones, 5'd16), 0, ST_OK);
    add_row(mk(CMD_DATA, '0, 5'd31), 0, ST_OK);
    add_row(mk(CMD_DATA, rnd128(), 5'd1), 0, ST_OK);
    add_row(mk(CMD_DATA, rnd128(), 5'd16), 1, ST_ORDER);
    add_row(mk(CMD_AAD, rnd128(), 5'd16), 1, ST_ORDER);
    add_row(mk(CMD_FINISH, ones, 5'd31), 0, ST_OK);
    add_row(mk(CMD_DATA, rnd128(), 5'd16), 1, ST_ORDER);
    add_row(mk(CMD_FINISH, rnd128(), 5'd16), 1, ST_ORDER);
    add_row(mk(CMD_START, rnd128(), 5'd31), 1, ST_OK);
    add_row(mk(CMD_FINISH, '0, 5'd0), 0, ST_OK);
    add_row(mk(CMD_START, ones, 5'd16), 1, ST_OK);
    add_row(mk(CMD_DATA, rnd128(), 5'd8), 0, ST_OK);
    add_row(mk(CMD_DATA, rnd128(), 5'd9), 1, ST_ORDER);
    add_row(mk(CMD_FINISH, rnd128(), 5'd0), 0, ST_OK);
    foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].res);

    // extremes of the configuration, decrypt with a wrong tag
    write_config('1, '1, 1'b1);
    send_item(mk(CMD_START, '0, 5'd0), 0, '0);
    send_item(mk(CMD_DATA, ones, 5'd16), 0, '0);
    send_item(mk(CMD_FINISH, ones, 5'd0), 0, '0);
    items = 25;

    // random messages with some noise and a new configuration now and then
    while (items < 1300) begin
      if ($urandom_range(0, 19) == 0)
        write_config({rnd128(), rnd128()}, {$urandom, $urandom, $urandom}, 1'($urandom));
      if ($urandom_range(0, 6) == 0) begin
        send_item(mk(cmd_e'($urandom_range(0, 3)), rnd128(), 5'($urandom_range(0, 31))), 0, '0);
        items++;
        continue;
      end
      send_item(mk(CMD_START, rnd128(), 5'($urandom_range(0, 31))), 0, '0);
      n_aad = $urandom_range(0, 3);
      n_data = $urandom_range(0, 6);
      for (int i = 0; i < n_aad; i++)
        send_item(mk(CMD_AAD, rnd128(), (i == n_aad - 1) ? rnd_len() : 5'd16), 0, '0);
      for (int i = 0; i < n_data; i++)
        send_item(mk(CMD_DATA, rnd128(), (i == n_data - 1) ? rnd_len() : 5'd16), 0, '0);
      if ($urandom_range(0, 9) == 0)
        send_item(mk(CMD_DATA, rnd128(), 5'd16), 0, '0);
      t = rnd128();
      if (dec_mode && msg_phase != PH_DONE && $urandom_range(0, 9) < 7) t = tag_now();
      send_item(mk(CMD_FINISH, t, 5'($urandom_range(0, 31))), 0, '0);
      items += n_aad + n_data + 2;
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
